>>> src/hscd_pkg.sv
// hscd_pkg: shared types, constants and crc-16/modbus helpers for the header sync deframer
// no dependencies
`timescale 1ns / 1ps

package hscd_pkg;

    localparam int PATTERN_BYTES     = 8;
    localparam int WINDOW_W          = PATTERN_BYTES * 8;
    localparam int FRAME_LEN_DEFAULT = 64;
    localparam int CFG_INDEX_W       = 8;
    localparam int FILL_W            = $clog2(PATTERN_BYTES + 1);
    localparam int BYTE_CNT_W        = $clog2(PATTERN_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEADER = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_POLL     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FOREIGN_A    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FOREIGN_B    = 8'd3;

    typedef enum logic [1:0] {
        EV_FRAME_START = 2'd0,
        EV_FRAME_BYTE  = 2'd1,
        EV_FRAME_END   = 2'd2,
        EV_OWN_POLL    = 2'd3
    } event_kind_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [WINDOW_W-1:0] frame_header;
        logic [WINDOW_W-1:0] own_poll;
        logic [WINDOW_W-1:0] foreign_a;
        logic [WINDOW_W-1:0] foreign_b;
        logic [15:0]         header_crc;
        logic                busy;
    } cfg_t;

    // one byte through the reflected crc, eight bit steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // whole pattern, oldest byte first; used for elaboration constants only
    function automatic logic [15:0] crc16_pattern(input logic [WINDOW_W-1:0] p);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = PATTERN_BYTES - 1; i >= 0; i--) begin
            c = crc16_byte(c, p[i*8 +: 8]);
        end
        return c;
    endfunction

    localparam logic [15:0] HEADER_CRC_RESET = crc16_pattern('0);

endpackage

>>> src/hscd_cfg.sv
// hscd_cfg: configuration registers and serial crc precompute over the header pattern
// depends on hscd_pkg
`timescale 1ns / 1ps

module hscd_cfg
    import hscd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WINDOW_W-1:0]    cfg_data,
    output cfg_t                   cfg
);

    logic [WINDOW_W-1:0]   header_reg;
    logic [WINDOW_W-1:0]   own_reg;
    logic [WINDOW_W-1:0]   foreign_a_reg;
    logic [WINDOW_W-1:0]   foreign_b_reg;
    logic [15:0]           hcrc_reg;
    logic [15:0]           hcrc_next;
    logic [WINDOW_W-1:0]   shift_reg;
    logic [BYTE_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  wr;

    assign wr        = cfg_valid && cfg_ready;
    assign cfg_ready = !busy_reg;
    assign hcrc_next = crc16_byte(hcrc_reg, shift_reg[WINDOW_W-1 -: 8]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= '0;
            own_reg       <= '0;
            foreign_a_reg <= '0;
            foreign_b_reg <= '0;
            hcrc_reg      <= HEADER_CRC_RESET;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (busy_reg)
        begin
            // one header byte per cycle, oldest first
            hcrc_reg <= hcrc_next;
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == BYTE_CNT_W'(PATTERN_BYTES - 1))
                busy_reg <= 1'b0;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                REG_FRAME_HEADER:
                begin
                    header_reg <= cfg_data;
                    hcrc_reg   <= CRC_INIT;
                    cnt_reg    <= '0;
                    busy_reg   <= 1'b1;
                end
                REG_OWN_POLL:  own_reg       <= cfg_data;
                REG_FOREIGN_A: foreign_a_reg <= cfg_data;
                REG_FOREIGN_B: foreign_b_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            shift_reg <= shift_reg << 8;
        else if (wr && cfg_index == REG_FRAME_HEADER)
            shift_reg <= cfg_data;
    end

    always_comb
    begin
        cfg.frame_header = header_reg;
        cfg.own_poll     = own_reg;
        cfg.foreign_a    = foreign_a_reg;
        cfg.foreign_b    = foreign_b_reg;
        cfg.header_crc   = hcrc_reg;
        cfg.busy         = busy_reg;
    end

endmodule

>>> src/hscd_core.sv
// hscd_core: input register, window match, frame tracking with crc, result register
// depends on hscd_pkg
`timescale 1ns / 1ps

module hscd_core
    import hscd_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic        crc_good,
    output logic [31:0] crc_fail_total
);

    localparam logic [7:0] TAIL_LO_IDX = 8'(FRAME_LEN - 2);
    localparam logic [7:0] START_IDX   = 8'(PATTERN_BYTES - 1);
    localparam logic [7:0] FIRST_BODY  = 8'(PATTERN_BYTES);

    // input stage
    logic        iv_reg;
    logic [7:0]  ib_reg;

    // deframer state
    logic [WINDOW_W-1:0] win_reg,  win_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                frm_reg,  frm_next;
    logic [7:0]          cnt_reg,  cnt_next;
    logic [15:0]         crc_reg,  crc_next;
    logic [15:0]         tail_reg, tail_next;
    logic [31:0]         fail_reg, fail_next;

    // result stage
    logic        ov_reg;
    event_kind_t kind_reg, kind_next;
    logic [7:0]  data_reg;
    logic [7:0]  idx_reg,  idx_next;
    logic        good_reg, good_next;
    logic        emit;

    logic advance;
    logic load_in;
    logic good;
    logic [15:0] crc_upd;

    assign advance  = iv_reg && !cfg.busy && (!ov_reg || !out_stall);
    assign in_stall = cfg.busy || (iv_reg && !advance);
    assign load_in  = in_valid && !in_stall;
    assign crc_upd  = crc16_byte(crc_reg, ib_reg);
    assign good     = ({ib_reg, tail_reg[7:0]} == crc_reg);

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        frm_next  = frm_reg;
        cnt_next  = cnt_reg;
        crc_next  = crc_reg;
        tail_next = tail_reg;
        fail_next = fail_reg;
        emit      = 1'b0;
        kind_next = EV_FRAME_BYTE;
        idx_next  = cnt_reg;
        good_next = 1'b0;
        if (frm_reg)
        begin
            emit = 1'b1;
            if (cnt_reg < TAIL_LO_IDX)
            begin
                crc_next = crc_upd;
                cnt_next = cnt_reg + 8'd1;
            end
            else if (cnt_reg == TAIL_LO_IDX)
            begin
                tail_next = {tail_reg[15:8], ib_reg};
                cnt_next  = cnt_reg + 8'd1;
            end
            else
            begin
                // closing checksum byte
                tail_next = {ib_reg, tail_reg[7:0]};
                good_next = good;
                if (!good && fail_reg != 32'hFFFF_FFFF)
                    fail_next = fail_reg + 32'd1;
                frm_next  = 1'b0;
                cnt_next  = '0;
                fill_next = '0;
                crc_next  = CRC_INIT;
                kind_next = EV_FRAME_END;
            end
        end
        else
        begin
            win_next = {win_reg[WINDOW_W-9:0], ib_reg};
            if (fill_reg != FILL_W'(PATTERN_BYTES))
                fill_next = fill_reg + 1'b1;
            if (fill_next == FILL_W'(PATTERN_BYTES))
            begin
                if (win_next == cfg.frame_header)
                begin
                    // window equals the pattern, so its crc is the precomputed one
                    crc_next  = cfg.header_crc;
                    tail_next = '0;
                    cnt_next  = FIRST_BODY;
                    frm_next  = 1'b1;
                    emit      = 1'b1;
                    kind_next = EV_FRAME_START;
                    idx_next  = START_IDX;
                end
                else if (win_next == cfg.own_poll)
                begin
                    fill_next = '0;
                    emit      = 1'b1;
                    kind_next = EV_OWN_POLL;
                    idx_next  = '0;
                end
                else if (win_next == cfg.foreign_a || win_next == cfg.foreign_b)
                begin
                    fill_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg   <= 1'b0;
            ov_reg   <= 1'b0;
            win_reg  <= '0;
            fill_reg <= '0;
            frm_reg  <= 1'b0;
            cnt_reg  <= '0;
            crc_reg  <= CRC_INIT;
            tail_reg <= '0;
            fail_reg <= '0;
        end
        else
        begin
            if (load_in)
                iv_reg <= 1'b1;
            else if (advance)
                iv_reg <= 1'b0;

            if (advance)
            begin
                win_reg  <= win_next;
                fill_reg <= fill_next;
                frm_reg  <= frm_next;
                cnt_reg  <= cnt_next;
                crc_reg  <= crc_next;
                tail_reg <= tail_next;
                fail_reg <= fail_next;
            end

            if (advance && emit)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
            ib_reg <= rx_byte;
        if (advance && emit)
        begin
            kind_reg       <= kind_next;
            data_reg       <= ib_reg;
            idx_reg        <= idx_next;
            good_reg       <= good_next;
            crc_fail_total <= fail_next;
        end
    end

    assign out_valid  = ov_reg;
    assign event_kind = kind_reg;
    assign data_byte  = data_reg;
    assign byte_index = idx_reg;
    assign crc_good   = good_reg;

endmodule

>>> src/header_sync_crc_deframer.sv
// header_sync_crc_deframer: top level, header/poll sync with crc-16/modbus frame check
// depends on hscd_pkg, hscd_cfg, hscd_core
// registers: an accepted item passes the input register, then the result register
// throughput: one item per cycle unless stalled; a held result stalls input at once
// a write to the frame header register runs a bytewise crc pass, input stalled meanwhile
// reset: asynchronous, active low; window empty, idle, crc preset, failure count zero
`timescale 1ns / 1ps

module header_sync_crc_deframer
    import hscd_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WINDOW_W-1:0]    cfg_data,
    // received bytes
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,
    // events
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             event_kind,
    output logic [7:0]             data_byte,
    output logic [7:0]             byte_index,
    output logic                   crc_good,
    output logic [31:0]            crc_fail_total
);

    // patterns, precomputed header crc and busy flag
    cfg_t cfg;

    // register file; the header crc is worked out byte by byte after each header write,
    // so a matched header loads the crc of all eight header bytes in one go
    hscd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // rolling window compare while idle, per-byte crc and tail capture inside a frame
    hscd_core #(
        .FRAME_LEN (FRAME_LEN)
    ) u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .crc_good       (crc_good),
        .crc_fail_total (crc_fail_total)
    );

endmodule

>>> tb/hscd_tb_pkg.sv
// hscd_tb_pkg: event record, crc-16/modbus step and the event scoreboard for the deframer bench
// depends on hscd_pkg
`timescale 1ns / 1ps

package hscd_tb_pkg;

    import hscd_pkg::*;

    localparam int FRAME_LEN = FRAME_LEN_DEFAULT;

    typedef struct {
        event_kind_t kind;
        logic [7:0]  data;
        logic [7:0]  idx;
        logic        good;
        logic [31:0] fails;
    } deframer_event_t;

    // reflected crc, one byte, lsb first
    function automatic bit [15:0] modbus_next(input bit [15:0] acc, input bit [7:0] b);
        bit [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    class event_scoreboard;

        logic [63:0]     patterns [4];
        bit [63:0]       recent;
        int unsigned     fill;
        bit              framing;
        int unsigned     pos;
        bit [15:0]       crc_acc;
        bit [15:0]       tail;
        bit [31:0]       fails;
        deframer_event_t awaited_events [$];
        int unsigned     mismatches;

        function new();
            foreach (patterns[i])
                patterns[i] = '0;
            recent     = '0;
            fill       = 0;
            framing    = 1'b0;
            pos        = 0;
            crc_acc    = CRC_INIT;
            tail       = '0;
            fails      = '0;
            mismatches = 0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
            // indexes past the last register are dropped
            if (idx <= REG_FOREIGN_B)
                patterns[idx] = val;
        endfunction

        // accepted input byte: advance the state and queue the event it causes, if any
        function void note_byte(input bit [7:0] b);
            deframer_event_t ev;
            bit [15:0]       hc;
            ev.data  = b;
            ev.good  = 1'b0;
            if (framing)
            begin
                ev.idx  = 8'(pos);
                ev.kind = EV_FRAME_BYTE;
                if (pos < FRAME_LEN - 2)
                begin
                    crc_acc = modbus_next(crc_acc, b);
                    pos++;
                end
                else if (pos == FRAME_LEN - 2)
                begin
                    tail[7:0] = b;
                    pos++;
                end
                else
                begin
                    tail[15:8] = b;
                    ev.good    = (tail == crc_acc);
                    if (!ev.good && fails != '1)
                        fails++;
                    framing = 1'b0;
                    pos     = 0;
                    fill    = 0;
                    crc_acc = CRC_INIT;
                    ev.kind = EV_FRAME_END;
                end
                ev.fails = fails;
                awaited_events.insert(awaited_events.size(), ev);
                return;
            end
            recent = {recent[55:0], b};
            if (fill < PATTERN_BYTES)
                fill++;
            if (fill < PATTERN_BYTES)
                return;
            ev.fails = fails;
            if (recent == patterns[REG_FRAME_HEADER])
            begin
                hc = CRC_INIT;
                for (int i = PATTERN_BYTES - 1; i >= 0; i--)
                    hc = modbus_next(hc, recent[i*8 +: 8]);
                crc_acc = hc;
                tail    = '0;
                pos     = PATTERN_BYTES;
                framing = 1'b1;
                ev.kind = EV_FRAME_START;
                ev.idx  = 8'(PATTERN_BYTES - 1);
                awaited_events.insert(awaited_events.size(), ev);
            end
            else if (recent == patterns[REG_OWN_POLL])
            begin
                fill    = 0;
                ev.kind = EV_OWN_POLL;
                ev.idx  = 8'd0;
                awaited_events.insert(awaited_events.size(), ev);
            end
            else if (recent == patterns[REG_FOREIGN_A] || recent == patterns[REG_FOREIGN_B])
                fill = 0;
        endfunction

        function void check_event(input deframer_event_t got);
            deframer_event_t want;
            if (awaited_events.size() == 0)
            begin
                $error("unexpected event: kind %0d byte %0h index %0d", got.kind, got.data, got.idx);
                mismatches++;
                return;
            end
            want = awaited_events[0];
            awaited_events.delete(0);
            if (got.kind !== want.kind)
            begin
                $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.data !== want.data)
            begin
                $error("data_byte: expected %0h, got %0h", want.data, got.data);
                mismatches++;
            end
            if (got.idx !== want.idx)
            begin
                $error("byte_index: expected %0d, got %0d", want.idx, got.idx);
                mismatches++;
            end
            if (got.good !== want.good)
            begin
                $error("crc_good: expected %0b, got %0b", want.good, got.good);
                mismatches++;
            end
            if (got.fails !== want.fails)
            begin
                $error("crc_fail_total: expected %0d, got %0d", want.fails, got.fails);
                mismatches++;
            end
        endfunction

    endclass

endpackage

>>> tb/tb_header_sync_crc_deframer.sv
// tb_header_sync_crc_deframer: drives bus bytes and register writes into the deframer
// and checks every event against the scoreboard; depends on hscd_pkg, hscd_tb_pkg and header_sync_crc_deframer
`timescale 1ns / 1ps

module tb_header_sync_crc_deframer;

    import hscd_pkg::*;
    import hscd_tb_pkg::*;

    // indexes past the register file, writes there must leave everything alone
    localparam logic [CFG_INDEX_W-1:0] REG_STRAY_FIRST = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STRAY_LAST  = 8'hFF;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_AT       = 450;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned CALM_FIRST    = 900;
    localparam int unsigned CALM_LAST     = 1150;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WINDOW_W-1:0]    cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             event_kind;
    logic [7:0]             data_byte;
    logic [7:0]             byte_index;
    logic                   crc_good;
    logic [31:0]            crc_fail_total;

    event_scoreboard sb;
    int unsigned     items_in = 0;
    int              cycles   = 0;

    header_sync_crc_deframer #(
        .FRAME_LEN (FRAME_LEN)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .crc_good       (crc_good),
        .crc_fail_total (crc_fail_total)
    );

    always #2 clk = ~clk;

    // hard stop in case the block locks up
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // stretch of items with no idling on either side
    function automatic bit calm_stretch();
        return items_in >= CALM_FIRST && items_in < CALM_LAST;
    endfunction

    // receiver: random stall, plus one long hold-off while the sender keeps offering
    initial
    begin
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && items_in >= HOLD_AT)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= !calm_stretch() && ($urandom_range(99) < 22);
        end
    end

    // event monitor, samples the pre-edge values of the outputs
    always @(posedge clk)
    begin
        deframer_event_t seen;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen.kind  = event_kind_t'(event_kind);
            seen.data  = data_byte;
            seen.idx   = byte_index;
            seen.good  = crc_good;
            seen.fails = crc_fail_total;
            sb.check_event(seen);
        end
    end

    function automatic logic [63:0] rand_pattern();
        return {$urandom, $urandom};
    endfunction

    // body bytes lean towards the extremes now and then
    function automatic bit [7:0] body_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // one register write; the caller drops cfg_valid after the last write of a batch
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // full register set; a header write starts the block's own crc pass over the pattern
    task automatic program_regs(input logic [63:0] hdr, input logic [63:0] own,
                                input logic [63:0] fa, input logic [63:0] fb,
                                input bit with_stray);
        write_reg(REG_FRAME_HEADER, hdr);
        write_reg(REG_OWN_POLL, own);
        write_reg(REG_FOREIGN_A, fa);
        write_reg(REG_FOREIGN_B, fb);
        if (with_stray)
        begin
            write_reg(REG_STRAY_FIRST, rand_pattern());
            write_reg(REG_STRAY_LAST, '1);
        end
        cfg_valid <= 1'b0;
    endtask

    // one item; a random gap before some items keeps the sender idle about a fifth
    // of the time, and only ever lowers valid in a step of its own
    task automatic send_byte(input bit [7:0] b);
        if (!calm_stretch() && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_byte(b);
        items_in++;
    endtask

    // eight bytes, oldest first, so the window lines up with the register
    task automatic send_pattern(input logic [63:0] p);
        for (int i = PATTERN_BYTES - 1; i >= 0; i--)
            send_byte(p[i*8 +: 8]);
    endtask

    // header, random body, then the checksum low byte first; about a third corrupted
    task automatic send_frame();
        logic [63:0] hdr;
        bit [15:0]   sum;
        bit [7:0]    b;
        hdr = sb.patterns[REG_FRAME_HEADER];
        sum = CRC_INIT;
        for (int i = PATTERN_BYTES - 1; i >= 0; i--)
        begin
            b   = hdr[i*8 +: 8];
            sum = modbus_next(sum, b);
            send_byte(b);
        end
        for (int i = 0; i < FRAME_LEN - PATTERN_BYTES - 2; i++)
        begin
            b   = body_byte();
            sum = modbus_next(sum, b);
            send_byte(b);
        end
        if ($urandom_range(99) >= 65)
            sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
        send_byte(sum[7:0]);
        send_byte(sum[15:8]);
    endtask

    // stray bytes, often a broken-off start of one of the patterns
    task automatic send_noise();
        logic [63:0] p;
        int unsigned prefix;
        int unsigned extra;
        p      = sb.patterns[$urandom_range(3)];
        prefix = $urandom_range(1) ? $urandom_range(1, PATTERN_BYTES - 1) : 0;
        extra  = $urandom_range(prefix == 0 ? 1 : 0, 4);
        for (int i = 0; i < prefix; i++)
            send_byte(p[(PATTERN_BYTES - 1 - i)*8 +: 8]);
        repeat (extra)
            send_byte(8'($urandom));
    endtask

    // mostly well-formed frames and polls, the rest noise
    task automatic run_traffic(input int unsigned count);
        int unsigned first;
        int unsigned pick;
        first = items_in;
        while (items_in - first < count)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_frame();
            else if (pick < 60)
                send_pattern(sb.patterns[REG_OWN_POLL]);
            else if (pick < 70)
                send_pattern(sb.patterns[REG_FOREIGN_A]);
            else if (pick < 78)
                send_pattern(sb.patterns[REG_FOREIGN_B]);
            else
                send_noise();
        end
    endtask

    // sender pauses until every event is back, then lets the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] shared;
        sb        = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: partial window, own poll, foreign poll
        program_regs(rand_pattern(), rand_pattern(), rand_pattern(), rand_pattern(), 1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_pattern(sb.patterns[REG_OWN_POLL]);
        send_pattern(sb.patterns[REG_FOREIGN_A]);
        drain();

        // distinct patterns, with a full drain halfway through
        program_regs(rand_pattern(), rand_pattern(), rand_pattern(), rand_pattern(), 1'b0);
        run_traffic(150);
        drain();
        run_traffic(150);
        drain();

        // all patterns zero: header takes priority over every poll
        program_regs('0, '0, '0, '0, 1'b0);
        run_traffic(300);
        drain();

        // header all ones; own poll equal to a foreign one, so the own poll wins
        shared = rand_pattern();
        program_regs('1, shared, shared, '0, 1'b0);
        run_traffic(300);
        drain();

        // header equal to own poll, plus writes to indexes that do not exist
        shared = rand_pattern();
        program_regs(shared, shared, rand_pattern(), '1, 1'b1);
        run_traffic(300);
        drain();

        // distinct again with own poll all ones
        program_regs(rand_pattern(), '1, rand_pattern(), rand_pattern(), 1'b0);
        run_traffic(300);
        drain();

        if (sb.mismatches == 0 && sb.awaited_events.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
src/hscd_pkg.sv
src/hscd_cfg.sv
src/hscd_core.sv
src/header_sync_crc_deframer.sv
tb/hscd_tb_pkg.sv
tb/tb_header_sync_crc_deframer.sv
